[rtl/length_prefixed_record_ring_assert.svh]
// assertion macros for the record ring checks
`ifndef LENGTH_PREFIXED_RECORD_RING_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_RING_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LPRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LPRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lprr_pkg.sv]
// shared constants, types and ring index helpers of the record ring
package lprr_pkg;

  localparam int DEPTH        = 1024;
  localparam int MAX_RECORD   = 64;
  localparam int HEADER_BYTES = 4;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int LEN_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 2;
  localparam int MREC_W  = $clog2(MAX_RECORD + 1);
  localparam int RD_W    = $clog2(((MAX_RECORD > HEADER_BYTES) ? MAX_RECORD : HEADER_BYTES) + 1);
  localparam int HK_W    = $clog2(HEADER_BYTES + 1);
  localparam int HC_W    = $clog2(HEADER_BYTES);
  localparam int HDR_W   = BYTE_W * HEADER_BYTES;
  localparam int SUM_W   = ((CAP_W > LEN_W) ? CAP_W : LEN_W) + 2;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((DEPTH < 1024) ? DEPTH : 1024);

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRIM  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

  // result codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_ERR   = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_USE_HEADER = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDRW,
    S_RHDR,
    S_RCHK,
    S_RDAT
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             use_header;
    logic             wr;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] wr_index;
    logic [IDX_W-1:0] rd_index;
  } stat_t;

  function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] i,
                                                input logic [CAP_W-1:0] cap);
    logic [SUM_W-1:0] nx;
    nx = SUM_W'(i) + SUM_W'(1);
    return (nx >= SUM_W'(cap)) ? '0 : IDX_W'(nx);
  endfunction

  // one conditional subtract, valid for x below twice the capacity
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] x,
                                                 input logic [CAP_W-1:0] cap);
    logic [SUM_W-1:0] y;
    y = (x >= SUM_W'(cap)) ? (x - SUM_W'(cap)) : x;
    return IDX_W'(y);
  endfunction

  function automatic logic [CAP_W-1:0] ring_occ(input logic [IDX_W-1:0] wi,
                                                input logic [IDX_W-1:0] ri,
                                                input logic [CAP_W-1:0] cap);
    logic [SUM_W-1:0] d;
    if (wi >= ri) begin
      d = SUM_W'(wi) - SUM_W'(ri);
    end else begin
      d = SUM_W'(wi) + SUM_W'(cap) - SUM_W'(ri);
    end
    return CAP_W'(d);
  endfunction

endpackage

[rtl/lprr_if.sv]
// request and result channel interfaces of the record ring
interface lprr_req_if import lprr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  length;

  modport source (output valid, cmd, data_byte, length, input ready);
  modport sink (input valid, cmd, data_byte, length, output ready);
endinterface

interface lprr_res_if import lprr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] out_byte;
  logic [ST_W-1:0]   status;
  logic [LEN_W-1:0]  count;
  logic              last;

  modport source (output valid, kind, out_byte, status, count, last, input ready);
  modport sink (input valid, kind, out_byte, status, count, last, output ready);
endinterface

[rtl/lprr_ram.sv]
// generic simple dual-port ram, registered read that holds when not enabled
module lprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lprr_cfg.sv]
// configuration registers behind the apb-style port
module lprr_cfg import lprr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CAP_W-1:0] capacity;
  logic             use_header;
  logic             wr;
  logic [LEN_W-1:0] wval;
  logic [CAP_W-1:0] cap_clamped;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign wval   = pwdata[LEN_W-1:0];

  always_comb begin
    if (wval == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (SUM_W'(wval) > SUM_W'(DEPTH)) begin
      cap_clamped = CAP_W'(DEPTH);
    end else begin
      cap_clamped = CAP_W'(wval);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      use_header <= 1'b1;
    end else if (wr) begin
      if (paddr[2] == REG_CAPACITY) begin
        capacity <= cap_clamped;
      end else begin
        use_header <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_USE_HEADER) ? PDATA_W'(use_header) : PDATA_W'(capacity);

  assign cfg.capacity   = capacity;
  assign cfg.use_header = use_header;
  assign cfg.wr         = wr;

endmodule

[rtl/lprr_outq.sv]
// two-entry result queue in front of the result channel
module lprr_outq import lprr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_t      d,
  output logic      space,
  lprr_res_if.source rsp
);

  res_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       pop;
  res_t       head;

  assign space = (fill != 2'd2);
  assign pop   = rsp.valid && rsp.ready;
  assign head  = ent[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= d;
    end
  end

  assign rsp.valid    = (fill != 2'd0);
  assign rsp.kind     = head.kind;
  assign rsp.out_byte = head.out_byte;
  assign rsp.status   = head.status;
  assign rsp.count    = head.count;
  assign rsp.last     = head.last;

endmodule

[rtl/lprr_seq.sv]
// command sequencer: ring indices, open record, header writes and record reads
module lprr_seq import lprr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lprr_req_if.sink          req,
  input  cfg_t              cfg,
  input  logic              res_space,
  output logic              res_push,
  output res_t              res,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output stat_t             stat
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  wi, wi_next;
  logic [IDX_W-1:0]  ri, ri_next;
  logic [MREC_W-1:0] p_rem, p_rem_next;
  logic [IDX_W-1:0]  p_cur, p_cur_next;
  logic              p_rej, p_rej_next;
  logic [MREC_W-1:0] p_tot, p_tot_next;
  logic [BYTE_W-1:0] lat_byte, lat_byte_next;
  logic [MREC_W-1:0] lat_len, lat_len_next;
  logic [MREC_W-1:0] eff_r, eff_r_next;
  logic              is_pop, is_pop_next;
  logic [HK_W-1:0]   hdr_k, hdr_k_next;
  logic [HC_W-1:0]   hdr_cnt, hdr_cnt_next;
  logic [HDR_W-1:0]  hdr_word, hdr_word_next;
  logic [IDX_W-1:0]  rd_addr, rd_addr_next;
  logic [RD_W-1:0]   rd_left, rd_left_next;
  logic [MREC_W-1:0] out_left, out_left_next;
  logic [MREC_W-1:0] sz, sz_next;
  logic              pend, pend_next;

  logic              in_acc;
  logic [CAP_W-1:0]  occ;
  logic [SUM_W-1:0]  hdr_s;
  logic [MREC_W-1:0] len_in;
  logic [MREC_W-1:0] eff_in;
  logic              push_fit;
  logic              rd_fit;
  logic              hdr_ok;
  logic [MREC_W-1:0] sz_hdr;

  logic              ds_go;
  logic [MREC_W-1:0] ds_rem;
  logic              ds_rej;
  logic [IDX_W-1:0]  ds_cur;
  logic [MREC_W-1:0] ds_tot;
  logic [BYTE_W-1:0] ds_byte;
  logic [MREC_W-1:0] ds_rem1;
  logic [IDX_W-1:0]  ds_cur1;
  logic [MREC_W-1:0] ds_tot1;
  logic              rew_chk;
  logic              rd_consume;

  assign req.ready = (state == S_IDLE) && res_space;
  assign in_acc    = req.valid && req.ready;

  assign occ    = ring_occ(wi, ri, cfg.capacity);
  assign hdr_s  = cfg.use_header ? SUM_W'(HEADER_BYTES) : '0;
  assign len_in = MREC_W'(req.length);
  assign eff_in = (req.length > LEN_W'(MAX_RECORD)) ? MREC_W'(MAX_RECORD) : len_in;

  assign push_fit = (SUM_W'(occ) + SUM_W'(req.length) + hdr_s) < SUM_W'(cfg.capacity);
  assign rd_fit   = SUM_W'(eff_in) <= SUM_W'(occ);

  // stored length is 32 bits, only a small value can pass the size check
  assign hdr_ok = (hdr_word[HDR_W-1:BYTE_W] == '0) &&
                  (SUM_W'(hdr_word[BYTE_W-1:0]) <= SUM_W'(eff_r)) &&
                  (SUM_W'(hdr_word[BYTE_W-1:0]) + SUM_W'(HEADER_BYTES) <= SUM_W'(occ));
  assign sz_hdr = MREC_W'(hdr_word[BYTE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wi      <= '0;
      ri      <= '0;
      p_rem   <= '0;
      p_cur   <= '0;
      p_rej   <= 1'b0;
      p_tot   <= '0;
      hdr_k   <= '0;
      hdr_cnt <= '0;
      rd_left <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      wi      <= wi_next;
      ri      <= ri_next;
      p_rem   <= p_rem_next;
      p_cur   <= p_cur_next;
      p_rej   <= p_rej_next;
      p_tot   <= p_tot_next;
      hdr_k   <= hdr_k_next;
      hdr_cnt <= hdr_cnt_next;
      rd_left <= rd_left_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    lat_byte <= lat_byte_next;
    lat_len  <= lat_len_next;
    eff_r    <= eff_r_next;
    is_pop   <= is_pop_next;
    hdr_word <= hdr_word_next;
    rd_addr  <= rd_addr_next;
    out_left <= out_left_next;
    sz       <= sz_next;
  end

  always_comb begin
    state_next    = state;
    wi_next       = wi;
    ri_next       = ri;
    p_rem_next    = p_rem;
    p_cur_next    = p_cur;
    p_rej_next    = p_rej;
    p_tot_next    = p_tot;
    lat_byte_next = lat_byte;
    lat_len_next  = lat_len;
    eff_r_next    = eff_r;
    is_pop_next   = is_pop;
    hdr_k_next    = hdr_k;
    hdr_cnt_next  = hdr_cnt;
    hdr_word_next = hdr_word;
    rd_addr_next  = rd_addr;
    rd_left_next  = rd_left;
    out_left_next = out_left;
    sz_next       = sz;

    ram_we    = 1'b0;
    ram_waddr = p_cur;
    ram_wdata = lat_byte;
    ram_re    = 1'b0;
    ram_raddr = rd_addr;

    res_push     = 1'b0;
    res          = '0;
    res.kind     = KIND_STATUS;
    res.status   = ST_OK;
    res.last     = 1'b1;

    ds_go      = 1'b0;
    ds_rem     = p_rem;
    ds_rej     = p_rej;
    ds_cur     = p_cur;
    ds_tot     = p_tot;
    ds_byte    = req.data_byte;
    ds_rem1    = '0;
    ds_cur1    = '0;
    ds_tot1    = '0;
    rew_chk    = 1'b0;
    rd_consume = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (req.cmd)
            CMD_PUSH: begin
              if (p_rem == '0) begin
                if ((req.length == '0) || (req.length > LEN_W'(MAX_RECORD))) begin
                  res_push   = 1'b1;
                  res.status = ST_ERR;
                end else if (push_fit && cfg.use_header) begin
                  // length header goes in first, data byte after it
                  p_rem_next    = len_in;
                  p_tot_next    = '0;
                  p_rej_next    = 1'b0;
                  p_cur_next    = wi;
                  lat_byte_next = req.data_byte;
                  lat_len_next  = len_in;
                  hdr_k_next    = '0;
                  state_next    = S_HDRW;
                end else begin
                  ds_go  = 1'b1;
                  ds_rem = len_in;
                  ds_rej = !push_fit;
                  ds_cur = wi;
                  ds_tot = '0;
                end
              end else begin
                ds_go = 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              is_pop_next = (req.cmd == CMD_POP);
              eff_r_next  = eff_in;
              if (req.length == '0) begin
                res_push   = 1'b1;
                res.status = ST_ERR;
              end else if (occ == '0) begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
                rew_chk    = 1'b1;
              end else if (cfg.use_header) begin
                rd_addr_next = ri;
                rd_left_next = RD_W'(HEADER_BYTES);
                hdr_cnt_next = '0;
                state_next   = S_RHDR;
              end else if (rd_fit) begin
                if (req.cmd == CMD_POP) begin
                  ri_next = ring_wrap(SUM_W'(ri) + SUM_W'(eff_in), cfg.capacity);
                end
                rew_chk       = 1'b1;
                rd_addr_next  = ri;
                rd_left_next  = RD_W'(eff_in);
                out_left_next = eff_in;
                sz_next       = eff_in;
                state_next    = S_RDAT;
              end else begin
                res_push   = 1'b1;
                res.status = ST_ERR;
              end
            end
            CMD_QUERY: begin
              res_push  = 1'b1;
              res.count = LEN_W'(occ);
            end
            CMD_TRIM: begin
              p_rem_next = '0;
              p_cur_next = '0;
              p_rej_next = 1'b0;
              p_tot_next = '0;
              res_push   = 1'b1;
              if (SUM_W'(cfg.capacity) > SUM_W'(req.length)) begin
                // keeps the modular start even when keep exceeds occupancy
                ri_next   = ring_wrap(SUM_W'(cfg.capacity) + SUM_W'(wi) - SUM_W'(req.length),
                                      cfg.capacity);
                res.count = req.length;
              end
            end
            CMD_CLEAR: begin
              p_rem_next = '0;
              p_cur_next = '0;
              p_rej_next = 1'b0;
              p_tot_next = '0;
              wi_next    = '0;
              ri_next    = '0;
              res_push   = 1'b1;
            end
            default: begin
              res_push   = 1'b1;
              res.status = ST_ERR;
            end
          endcase
        end
      end
      S_HDRW: begin
        if (hdr_k != HK_W'(HEADER_BYTES)) begin
          ram_we     = 1'b1;
          ram_waddr  = p_cur;
          ram_wdata  = (hdr_k == '0) ? BYTE_W'(lat_len) : '0;
          p_cur_next = ring_adv(p_cur, cfg.capacity);
          hdr_k_next = hdr_k + HK_W'(1);
        end else if (res_space) begin
          ds_go      = 1'b1;
          ds_byte    = lat_byte;
          state_next = S_IDLE;
        end
      end
      S_RHDR: begin
        rd_consume = pend;
        if (pend) begin
          hdr_word_next = {ram_rdata, hdr_word[HDR_W-1:BYTE_W]};
          hdr_cnt_next  = hdr_cnt + HC_W'(1);
          if (hdr_cnt == HC_W'(HEADER_BYTES - 1)) begin
            state_next = S_RCHK;
          end
        end
      end
      S_RCHK: begin
        if (hdr_ok && (sz_hdr != '0)) begin
          if (is_pop) begin
            ri_next = ring_wrap(SUM_W'(ri) + SUM_W'(sz_hdr) + SUM_W'(HEADER_BYTES),
                                cfg.capacity);
          end
          rew_chk       = 1'b1;
          rd_left_next  = RD_W'(sz_hdr);
          out_left_next = sz_hdr;
          sz_next       = sz_hdr;
          state_next    = S_RDAT;
        end else if (res_space) begin
          // zero-size record or a header that fails the checks
          res_push   = 1'b1;
          res.status = hdr_ok ? ST_OK : ST_ERR;
          if (hdr_ok && is_pop) begin
            ri_next = ring_wrap(SUM_W'(ri) + SUM_W'(HEADER_BYTES), cfg.capacity);
          end
          rew_chk    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RDAT: begin
        rd_consume = pend && res_space;
        if (rd_consume) begin
          res_push      = 1'b1;
          res.kind      = KIND_DATA;
          res.out_byte  = ram_rdata;
          res.count     = LEN_W'(sz);
          res.last      = (out_left == MREC_W'(1));
          out_left_next = out_left - MREC_W'(1);
          if (out_left == MREC_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // read issue: ram data holds until taken, so at most one byte in flight
    if (((state == S_RHDR) || (state == S_RDAT)) && (rd_left != '0) &&
        (!pend || rd_consume)) begin
      ram_re       = 1'b1;
      ram_raddr    = rd_addr;
      rd_addr_next = ring_adv(rd_addr, cfg.capacity);
      rd_left_next = rd_left - RD_W'(1);
    end
    pend_next = ram_re || (pend && !rd_consume);

    // one record byte of a push: store it or drop it
    if (ds_go) begin
      ds_rem1  = ds_rem - MREC_W'(1);
      res_push = 1'b1;
      if (ds_rej) begin
        res.status = ST_ERR;
        if (ds_rem1 == '0) begin
          p_rem_next = '0;
          p_cur_next = '0;
          p_rej_next = 1'b0;
          p_tot_next = '0;
        end else begin
          p_rem_next = ds_rem1;
          p_rej_next = 1'b1;
          p_tot_next = ds_tot;
        end
      end else begin
        ds_cur1    = ring_adv(ds_cur, cfg.capacity);
        ds_tot1    = ds_tot + MREC_W'(1);
        ram_we     = 1'b1;
        ram_waddr  = ds_cur;
        ram_wdata  = ds_byte;
        res.status = ST_OK;
        res.count  = LEN_W'(ds_tot1);
        if (ds_rem1 == '0) begin
          // commit the record
          wi_next    = ds_cur1;
          p_rem_next = '0;
          p_cur_next = '0;
          p_rej_next = 1'b0;
          p_tot_next = '0;
        end else begin
          p_rem_next = ds_rem1;
          p_cur_next = ds_cur1;
          p_tot_next = ds_tot1;
          p_rej_next = 1'b0;
        end
      end
    end

    // both indices back to zero once the ring drains with no record open
    if (rew_chk && (wi_next == ri_next) && (p_rem_next == '0)) begin
      wi_next = '0;
      ri_next = '0;
    end

    if (cfg.wr) begin
      wi_next    = '0;
      ri_next    = '0;
      p_rem_next = '0;
      p_cur_next = '0;
      p_rej_next = 1'b0;
      p_tot_next = '0;
    end
  end

  assign stat.wr_index = wi;
  assign stat.rd_index = ri;

endmodule

[rtl/length_prefixed_record_ring.sv]
// Record ring top level: a byte ring in one ram that stores length-prefixed records.
// Requests come in on req (cmd, data_byte, length) and are taken when valid and ready
// are both high; results leave on rsp (kind, out_byte, status, count, last), last high
// on the final result of a request. Registers: capacity at 0x0, use_header at 0x4.
// A push byte's result is registered in the result queue on its way to rsp, so a record
// streams in at one byte per cycle while the queue has space. The first byte of a record
// with the header on writes the four length bytes and then the data byte, which all
// share the single ram write port.
// Pop and peek with the header on read the four length bytes, check them in S_RCHK, then
// emit one record byte per cycle while the queue has space; without the header the
// request goes straight to the data reads. The ram read port and its registered read set this.
// Results go through a two-entry queue: a request is taken while a result still waits,
// and when rsp stalls the queue fills, ready drops and record reads pause in place.
// Reset empties the ring, sets capacity to 1024 and turns the header on; the ram is not
// cleared and needs no clearing pass. A register write also empties the ring and drops
// an open record.
module length_prefixed_record_ring import lprr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lprr_req_if.sink           req,
  lprr_res_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  `include "length_prefixed_record_ring_assert.svh"

  cfg_t              cfg;
  stat_t             stat;
  res_t              res;
  logic              res_push;
  logic              res_space;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  lprr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lprr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lprr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .stat      (stat)
  );

  lprr_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .d     (res),
    .space (res_space),
    .rsp   (rsp)
  );

  `LPRR_ASSERT_NOW(a_no_queue_overflow, res_push, res_space, "result pushed into a full queue")
  `LPRR_ASSERT_NEXT(a_cfg_empties_ring, cfg.wr, (stat.wr_index == '0) && (stat.rd_index == '0), "register write left the ring indices set")
  `LPRR_ASSERT_NOW(a_index_in_ring, 1'b1, (CAP_W'(stat.wr_index) < cfg.capacity) && (CAP_W'(stat.rd_index) < cfg.capacity), "ring index at or beyond capacity")
  `LPRR_ASSERT_NOW(a_write_in_ring, ram_we, CAP_W'(ram_waddr) < cfg.capacity, "ram write beyond capacity")

endmodule
